/* rtl/core/wsfd_pkg.sv */
package wsfd_pkg;

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_LEN,
        PH_EXTLEN,
        PH_KEY,
        PH_DATA,
        PH_DISCARD
    } t_phase;

    localparam logic [7:0] OP_TEXT   = 8'h81;
    localparam logic [7:0] OP_BINARY = 8'h82;
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_OPCODE = 2'd1;
    localparam logic [1:0] ERR_LENGTH = 2'd2;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       is_binary;
        logic       last_in_frame;
        logic [1:0] frame_error;
    } t_result;

endpackage

/* rtl/core/wsfd_parser.sv */
module wsfd_parser #(
    parameter int MAX_FRAME_BYTES = 2097152
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_data_byte,
    input  logic               i_chunk_start,
    output logic               o_res_valid,
    output wsfd_pkg::t_result  o_res
);

    localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [LEN_W+7:0] MAX_V = (LEN_W + 8)'(MAX_FRAME_BYTES);

    wsfd_pkg::t_phase r_phase, n_phase;
    logic [2:0]       r_hc, n_hc;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_masked, n_masked;
    logic [31:0]      r_key, n_key;
    logic [1:0]       r_ki, n_ki;
    logic             r_bin, n_bin;

    logic             op_ok;
    logic             new_frame;
    logic [6:0]       l7;
    logic [LEN_W+7:0] ext_v;
    logic             too_big;
    logic             ext_start;
    logic             len_done;
    logic             hdr_done;
    logic             len_zero;
    logic             data_last;
    logic [7:0]       key_byte;

    assign op_ok     = (i_data_byte == wsfd_pkg::OP_TEXT) || (i_data_byte == wsfd_pkg::OP_BINARY);
    assign new_frame = op_ok && (i_chunk_start || (r_phase == wsfd_pkg::PH_OPCODE));
    assign l7        = i_data_byte[6:0];
    assign ext_v     = {r_len, i_data_byte};
    assign too_big   = ext_v > MAX_V;

    always_comb begin
        case (r_ki)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    // datapath and result
    always_comb begin
        n_hc        = r_hc;
        n_len       = r_len;
        n_masked    = r_masked;
        n_key       = r_key;
        n_ki        = r_ki;
        n_bin       = r_bin;
        ext_start   = 1'b0;
        len_done    = 1'b0;
        hdr_done    = 1'b0;
        data_last   = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (new_frame) begin
            n_bin    = (i_data_byte == wsfd_pkg::OP_BINARY);
            n_hc     = '0;
            n_len    = '0;
            n_masked = 1'b0;
            n_key    = '0;
            n_ki     = '0;
        end else begin
            case (r_phase)
                wsfd_pkg::PH_OPCODE: begin
                    o_res_valid       = 1'b1;
                    o_res.frame_error = wsfd_pkg::ERR_OPCODE;
                end
                wsfd_pkg::PH_LEN: begin
                    n_masked = i_data_byte[7];
                    n_len    = '0;
                    if (l7 == wsfd_pkg::LEN_EXT16) begin
                        n_hc      = 3'd1;
                        ext_start = 1'b1;
                    end else if (l7 == wsfd_pkg::LEN_EXT64) begin
                        n_hc      = 3'd7;
                        ext_start = 1'b1;
                    end else begin
                        n_len    = LEN_W'(l7);
                        len_done = 1'b1;
                    end
                end
                wsfd_pkg::PH_EXTLEN: begin
                    if (too_big) begin
                        n_len             = '0;
                        o_res_valid       = 1'b1;
                        o_res.is_binary   = r_bin;
                        o_res.frame_error = wsfd_pkg::ERR_LENGTH;
                    end else begin
                        n_len = ext_v[LEN_W-1:0];
                        if (r_hc == 3'd0) begin
                            len_done = 1'b1;
                        end else begin
                            n_hc = r_hc - 3'd1;
                        end
                    end
                end
                wsfd_pkg::PH_KEY: begin
                    n_key = {r_key[23:0], i_data_byte};
                    if (r_hc == 3'd0) begin
                        hdr_done = 1'b1;
                    end else begin
                        n_hc = r_hc - 3'd1;
                    end
                end
                wsfd_pkg::PH_DATA: begin
                    n_ki                = r_ki + 2'd1;
                    n_len               = r_len - LEN_W'(1);
                    data_last           = (r_len == LEN_W'(1));
                    o_res_valid         = 1'b1;
                    o_res.payload_byte  = i_data_byte ^ (r_masked ? key_byte : 8'h00);
                    o_res.payload_valid = 1'b1;
                    o_res.is_binary     = r_bin;
                    o_res.last_in_frame = data_last;
                end
                default: begin
                end
            endcase
            if (len_done) begin
                if (n_masked) begin
                    n_hc  = 3'd3;
                    n_key = '0;
                end else begin
                    hdr_done = 1'b1;
                end
            end
            if (hdr_done) begin
                n_ki = '0;
                if (n_len == '0) begin
                    o_res_valid         = 1'b1;
                    o_res.is_binary     = r_bin;
                    o_res.last_in_frame = 1'b1;
                end
            end
        end
    end

    assign len_zero = (n_len == '0);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (new_frame) begin
            n_phase = wsfd_pkg::PH_LEN;
        end else begin
            unique case (r_phase) inside
                wsfd_pkg::PH_OPCODE: n_phase = wsfd_pkg::PH_DISCARD;
                wsfd_pkg::PH_LEN, wsfd_pkg::PH_EXTLEN, wsfd_pkg::PH_KEY: begin
                    if ((r_phase == wsfd_pkg::PH_EXTLEN) && too_big) begin
                        n_phase = wsfd_pkg::PH_DISCARD;
                    end else if (ext_start) begin
                        n_phase = wsfd_pkg::PH_EXTLEN;
                    end else if (len_done && n_masked) begin
                        n_phase = wsfd_pkg::PH_KEY;
                    end else if (hdr_done) begin
                        n_phase = len_zero ? wsfd_pkg::PH_OPCODE : wsfd_pkg::PH_DATA;
                    end
                end
                wsfd_pkg::PH_DATA: begin
                    if (data_last) begin
                        n_phase = wsfd_pkg::PH_OPCODE;
                    end
                end
                default: n_phase = wsfd_pkg::PH_DISCARD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= wsfd_pkg::PH_OPCODE;
            r_hc     <= '0;
            r_len    <= '0;
            r_masked <= 1'b0;
            r_key    <= '0;
            r_ki     <= '0;
            r_bin    <= 1'b0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_hc     <= n_hc;
            r_len    <= n_len;
            r_masked <= n_masked;
            r_key    <= n_key;
            r_ki     <= n_ki;
            r_bin    <= n_bin;
        end
    end

endmodule

/* rtl/core/wsfd_out_stage.sv */
module wsfd_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  wsfd_pkg::t_result  i_res,
    output logic               o_space,
    output logic               o_valid,
    input  logic               i_ready,
    output wsfd_pkg::t_result  o_res
);

    logic              r_out_valid;
    logic              r_skid_valid;
    wsfd_pkg::t_result r_out;
    wsfd_pkg::t_result r_skid;
    logic              pop;

    assign pop     = r_out_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // advance the skid beat, or land the new beat
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out <= i_res;
            end else begin
                r_skid <= i_res;
            end
        end
    end

endmodule

/* rtl/core/websocket_frame_deframer_unit.sv */
// Result beats are registered in the output stage; header walk and unmasking are single pass.
// Throughput: one input beat per cycle while the skid register is empty.
// A two-beat output stage (register plus skid) keeps the input open while a result waits.
// Reset (synchronous, active low) returns the parser to waiting for an opcode
// and empties the output stage.
module websocket_frame_deframer_unit #(
    parameter int MAX_FRAME_BYTES = 2097152
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,  // [7:0] data_byte
    input  logic       i_s_axis_tuser,  // [0] chunk_start
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,  // [7:0] payload_byte
    output logic [3:0] o_m_axis_tuser,  // [0] payload_valid, [1] is_binary, [3:2] frame_error
    output logic       o_m_axis_tlast   // last_in_frame
);

    logic              accept;
    logic              res_valid;
    wsfd_pkg::t_result res;
    wsfd_pkg::t_result out_res;
    logic              space;

    assign accept          = i_s_axis_tvalid && space;
    assign o_s_axis_tready = space;

    wsfd_parser #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_s_axis_tdata),
        .i_chunk_start(i_s_axis_tuser),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    wsfd_out_stage u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept && res_valid),
        .i_res  (res),
        .o_space(space),
        .o_valid(o_m_axis_tvalid),
        .i_ready(i_m_axis_tready),
        .o_res  (out_res)
    );

    assign o_m_axis_tdata = out_res.payload_byte;
    assign o_m_axis_tuser = {out_res.frame_error, out_res.is_binary, out_res.payload_valid};
    assign o_m_axis_tlast = out_res.last_in_frame;

endmodule

/* rtl/core/wsfd_checker.sv */
module wsfd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic [3:0] o_m_axis_tuser,
    input logic       o_m_axis_tlast
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat present after reset");

    a_error_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser[3:2] != 2'd0)
        |-> !o_m_axis_tlast && !o_m_axis_tuser[0] && (o_m_axis_tdata == 8'h00))
        else $error("error beat carries payload or end of frame");

    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] && (o_m_axis_tuser[3:2] == 2'd0)
        |-> o_m_axis_tlast && (o_m_axis_tdata == 8'h00))
        else $error("empty beat is not an end marker");

endmodule

bind websocket_frame_deframer_unit wsfd_checker u_wsfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tuser (o_m_axis_tuser),
    .o_m_axis_tlast (o_m_axis_tlast)
);

/* test/websocket_frame_deframer_unit_tb.sv */
module websocket_frame_deframer_unit_tb;

    localparam int MAX_FRAME = 2097152;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_BYTES = 400;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic       i_s_axis_tuser = 1'b0;    // [0] chunk_start
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;           // [7:0] payload_byte
    logic [3:0] o_m_axis_tuser;           // [0] payload_valid, [1] is_binary, [3:2] frame_error
    logic       o_m_axis_tlast;           // last_in_frame

    websocket_frame_deframer_unit #(
        .MAX_FRAME_BYTES(MAX_FRAME)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    wsfd_pkg::t_phase ps_phase = wsfd_pkg::PH_OPCODE;
    logic [2:0]  ps_hdr_left = '0;
    logic [21:0] ps_len_left = '0;
    logic        ps_masked = 1'b0;
    logic [31:0] ps_mask_key = '0;
    logic [1:0]  ps_key_idx = '0;
    logic        ps_binary = 1'b0;

    wsfd_pkg::t_result frame_out_q[$];
    wsfd_pkg::t_result want;
    logic [7:0]  tx_bytes[$];
    int          errors = 0;
    int          parsed_bytes = 0;
    int          burst_left = 0;
    int          cycle_count = 0;
    int          stall_mode = 0;
    int          stall_left = 0;

    task automatic push_result(input logic [7:0] pb, input logic pv, input logic bi,
                               input logic la, input logic [1:0] er);
        wsfd_pkg::t_result r;
        r = '{pb, pv, bi, la, er};
        frame_out_q.push_back(r);
    endtask

    task automatic finish_header();
        ps_key_idx = '0;
        if (ps_len_left == 0) begin
            ps_phase = wsfd_pkg::PH_OPCODE;
            push_result(8'h00, 1'b0, ps_binary, 1'b1, wsfd_pkg::ERR_NONE);
        end else begin
            ps_phase = wsfd_pkg::PH_DATA;
        end
    endtask

    task automatic finish_length();
        if (ps_masked) begin
            ps_phase = wsfd_pkg::PH_KEY;
            ps_hdr_left = 3'd3;
            ps_mask_key = '0;
        end else begin
            finish_header();
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b, input logic start);
        logic        op_ok;
        logic [63:0] grown;
        logic [7:0]  kb;
        op_ok = (b == wsfd_pkg::OP_TEXT) || (b == wsfd_pkg::OP_BINARY);
        if (ps_phase != wsfd_pkg::PH_DISCARD || (op_ok && start))
            parsed_bytes++;
        if (op_ok && (start || ps_phase == wsfd_pkg::PH_OPCODE)) begin
            ps_binary = (b == wsfd_pkg::OP_BINARY);
            ps_phase = wsfd_pkg::PH_LEN;
            ps_hdr_left = '0;
            ps_len_left = '0;
            ps_masked = 1'b0;
            ps_mask_key = '0;
            ps_key_idx = '0;
        end else begin
            case (ps_phase)
                wsfd_pkg::PH_OPCODE: begin
                    ps_phase = wsfd_pkg::PH_DISCARD;
                    push_result(8'h00, 1'b0, 1'b0, 1'b0, wsfd_pkg::ERR_OPCODE);
                end
                wsfd_pkg::PH_LEN: begin
                    ps_masked = b[7];
                    ps_len_left = '0;
                    if (b[6:0] == wsfd_pkg::LEN_EXT16) begin
                        ps_hdr_left = 3'd1;
                        ps_phase = wsfd_pkg::PH_EXTLEN;
                    end else if (b[6:0] == wsfd_pkg::LEN_EXT64) begin
                        ps_hdr_left = 3'd7;
                        ps_phase = wsfd_pkg::PH_EXTLEN;
                    end else begin
                        ps_len_left = {15'd0, b[6:0]};
                        finish_length();
                    end
                end
                wsfd_pkg::PH_EXTLEN: begin
                    grown = {34'd0, ps_len_left, b};
                    if (grown > 64'(MAX_FRAME)) begin
                        ps_phase = wsfd_pkg::PH_DISCARD;
                        ps_len_left = '0;
                        push_result(8'h00, 1'b0, ps_binary, 1'b0, wsfd_pkg::ERR_LENGTH);
                    end else begin
                        ps_len_left = grown[21:0];
                        if (ps_hdr_left == 0)
                            finish_length();
                        else
                            ps_hdr_left = ps_hdr_left - 3'd1;
                    end
                end
                wsfd_pkg::PH_KEY: begin
                    ps_mask_key = {ps_mask_key[23:0], b};
                    if (ps_hdr_left == 0)
                        finish_header();
                    else
                        ps_hdr_left = ps_hdr_left - 3'd1;
                end
                wsfd_pkg::PH_DATA: begin
                    kb = ps_masked ? 8'(ps_mask_key >> (24 - 8 * int'(ps_key_idx))) : 8'h00;
                    ps_key_idx = ps_key_idx + 2'd1;
                    ps_len_left = ps_len_left - 22'd1;
                    if (ps_len_left == 0)
                        ps_phase = wsfd_pkg::PH_OPCODE;
                    push_result(b ^ kb, 1'b1, ps_binary, ps_len_left == 0, wsfd_pkg::ERR_NONE);
                end
                default: begin
                    ps_phase = wsfd_pkg::PH_DISCARD;
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned got_val);
        if (exp_val != got_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, got_val);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                deframe_byte(i_s_axis_tdata, i_s_axis_tuser);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (frame_out_q.size() == 0) begin
                    $error("result beat with nothing outstanding");
                    errors++;
                end else begin
                    want = frame_out_q.pop_front();
                    check_field("payload_byte", want.payload_byte, o_m_axis_tdata);
                    check_field("payload_valid", want.payload_valid, o_m_axis_tuser[0]);
                    check_field("is_binary", want.is_binary, o_m_axis_tuser[1]);
                    check_field("last_in_frame", want.last_in_frame, o_m_axis_tlast);
                    check_field("frame_error", want.frame_error, o_m_axis_tuser[3:2]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: runs of always ready, coin-flip, mostly ready, mostly stalled
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 96);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= 1'($urandom_range(0, 1));
            2: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: i_m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_beat(input logic [7:0] data, input logic start);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= data;
        i_s_axis_tuser <= start;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic stop_input();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic send_tx(input logic first_start);
        foreach (tx_bytes[i])
            send_beat(tx_bytes[i], (i == 0) ? first_start : ($urandom_range(0, 9) == 0));
    endtask

    function automatic logic [7:0] payload_pick();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(0, 1) ? wsfd_pkg::OP_BINARY : wsfd_pkg::OP_TEXT;
        return 8'($urandom_range(0, 255));
    endfunction

    // form: 0 short length, 1 16-bit extended, 2 64-bit extended
    task automatic build_frame(input logic [7:0] op, input logic [63:0] len, input int form,
                               input logic masked, input logic [31:0] key,
                               input int n_payload);
        tx_bytes.delete();
        tx_bytes.push_back(op);
        case (form)
            0: tx_bytes.push_back({masked, len[6:0]});
            1: begin
                tx_bytes.push_back({masked, wsfd_pkg::LEN_EXT16});
                tx_bytes.push_back(len[15:8]);
                tx_bytes.push_back(len[7:0]);
            end
            default: begin
                tx_bytes.push_back({masked, wsfd_pkg::LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                    tx_bytes.push_back(len[8 * i +: 8]);
            end
        endcase
        if (masked)
            for (int i = 3; i >= 0; i--)
                tx_bytes.push_back(key[8 * i +: 8]);
        repeat (n_payload)
            tx_bytes.push_back(payload_pick());
    endtask

    task automatic send_list(input logic [8:0] beats[]);
        foreach (beats[i])
            send_beat(beats[i][7:0], beats[i][8]);
    endtask

    task automatic test_empty_frames();
        send_list('{{1'b1, wsfd_pkg::OP_TEXT}, 9'h000,
                    {1'b0, wsfd_pkg::OP_BINARY}, 9'h080, 9'h000, 9'h000, 9'h000, 9'h000});
    endtask

    task automatic test_masked_payload();
        send_list('{{1'b1, wsfd_pkg::OP_BINARY}, 9'h081, 9'h1ff, 9'h000, 9'h0aa, 9'h055,
                    9'h0ff});
    endtask

    task automatic test_extended_length();
        send_list('{{1'b1, wsfd_pkg::OP_TEXT}, 9'h07e, 9'h100, 9'h001, 9'h081});
    endtask

    task automatic test_bad_opcode_and_oversize();
        send_list('{9'h100, {1'b0, wsfd_pkg::OP_TEXT}, {1'b1, wsfd_pkg::OP_BINARY}, 9'h07f,
                    9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h020, 9'h000, 9'h001,
                    9'h005});
    endtask

    task automatic test_resync();
        send_list('{{1'b1, wsfd_pkg::OP_TEXT}, 9'h003, 9'h011, {1'b1, wsfd_pkg::OP_BINARY},
                    9'h000});
    endtask

    task automatic test_random_traffic();
        int          goal;
        int          pick;
        int          form;
        int          n;
        logic [63:0] len;
        logic [7:0]  op;
        goal = parsed_bytes + RANDOM_BYTES;
        while (parsed_bytes < goal) begin
            pick = $urandom_range(0, 99);
            op = $urandom_range(0, 1) ? wsfd_pkg::OP_BINARY : wsfd_pkg::OP_TEXT;
            if (pick < 84) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin form = 0; len = 64'($urandom_range(0, 5)); end
                    4, 5, 6:    begin form = 0; len = 64'($urandom_range(6, 125)); end
                    7:          begin form = 1; len = 64'($urandom_range(0, 140)); end
                    8:          begin form = 2; len = 64'($urandom_range(0, 30)); end
                    default:    begin form = 1; len = 64'($urandom_range(126, 135)); end
                endcase
                if (form == 0 && len > 40 && $urandom_range(0, 3) != 0)
                    len = 64'($urandom_range(6, 40));
                build_frame(op, len, form, 1'($urandom_range(0, 1)), $urandom, int'(len));
                if (pick >= 72) begin
                    n = $urandom_range(1, tx_bytes.size() - 1);
                    while (tx_bytes.size() > n)
                        void'(tx_bytes.pop_back());
                end
                send_tx($urandom_range(0, 5) != 0);
            end else if (pick < 92) begin
                do op = 8'($urandom_range(0, 255));
                while (op == wsfd_pkg::OP_TEXT || op == wsfd_pkg::OP_BINARY);
                tx_bytes.delete();
                tx_bytes.push_back(op);
                repeat ($urandom_range(0, 4))
                    tx_bytes.push_back(payload_pick());
                send_tx(1'($urandom_range(0, 1)));
            end else begin
                case ($urandom_range(0, 3))
                    0:       len = 64'(MAX_FRAME) + 64'd1 + 64'($urandom_range(0, 1000));
                    1:       len = {$urandom, $urandom};
                    2:       len = 64'(MAX_FRAME);
                    default: len = 64'($urandom_range(MAX_FRAME - 3, MAX_FRAME));
                endcase
                build_frame(op, len, 2, 1'($urandom_range(0, 1)), $urandom,
                            $urandom_range(0, 3));
                send_tx(1'b1);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_frames();
        test_masked_payload();
        test_extended_length();
        test_bad_opcode_and_oversize();
        test_resync();
        test_random_traffic();
        stop_input();
        while (frame_out_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
